// ----- sv/ast_pkg.sv -----
// Shared token, mode, error and character codes for the source tokenizer.
package ast_pkg;

  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_EOL      = 6'd1;
  localparam logic [5:0] K_NUMBER   = 6'd2;
  localparam logic [5:0] K_STRING   = 6'd3;
  localparam logic [5:0] K_CHAR     = 6'd4;
  localparam logic [5:0] K_IDENT    = 6'd5;
  localparam logic [5:0] K_LOCAL    = 6'd6;
  localparam logic [5:0] K_ABACK    = 6'd7;
  localparam logic [5:0] K_AFWD     = 6'd8;
  localparam logic [5:0] K_DIR      = 6'd9;
  localparam logic [5:0] K_MACRO    = 6'd10;
  localparam logic [5:0] K_PLUS     = 6'd11;
  localparam logic [5:0] K_MINUS    = 6'd12;
  localparam logic [5:0] K_STAR     = 6'd13;
  localparam logic [5:0] K_SLASH    = 6'd14;
  localparam logic [5:0] K_PERCENT  = 6'd15;
  localparam logic [5:0] K_AMP      = 6'd16;
  localparam logic [5:0] K_PIPE     = 6'd17;
  localparam logic [5:0] K_CARET    = 6'd18;
  localparam logic [5:0] K_TILDE    = 6'd19;
  localparam logic [5:0] K_BANG     = 6'd20;
  localparam logic [5:0] K_LT       = 6'd21;
  localparam logic [5:0] K_GT       = 6'd22;
  localparam logic [5:0] K_EQ       = 6'd23;
  localparam logic [5:0] K_NE       = 6'd24;
  localparam logic [5:0] K_LE       = 6'd25;
  localparam logic [5:0] K_GE       = 6'd26;
  localparam logic [5:0] K_LSHIFT   = 6'd27;
  localparam logic [5:0] K_RSHIFT   = 6'd28;
  localparam logic [5:0] K_LPAREN   = 6'd29;
  localparam logic [5:0] K_RPAREN   = 6'd30;
  localparam logic [5:0] K_LBRACE   = 6'd31;
  localparam logic [5:0] K_RBRACE   = 6'd32;
  localparam logic [5:0] K_LBRACKET = 6'd33;
  localparam logic [5:0] K_RBRACKET = 6'd34;
  localparam logic [5:0] K_COMMA    = 6'd35;
  localparam logic [5:0] K_COLON    = 6'd36;
  localparam logic [5:0] K_HASH     = 6'd37;
  localparam logic [5:0] K_ERROR    = 6'd38;
  localparam logic [5:0] K_BYTE     = 6'd39;

  localparam logic [4:0] M_START   = 5'd0;
  localparam logic [4:0] M_COMMENT = 5'd1;
  localparam logic [4:0] M_HEX     = 5'd2;
  localparam logic [4:0] M_PCT     = 5'd3;
  localparam logic [4:0] M_BIN     = 5'd4;
  localparam logic [4:0] M_DEC     = 5'd5;
  localparam logic [4:0] M_CH      = 5'd6;
  localparam logic [4:0] M_CHEND   = 5'd7;
  localparam logic [4:0] M_STR     = 5'd8;
  localparam logic [4:0] M_IDENT   = 5'd9;
  localparam logic [4:0] M_LOCAL   = 5'd10;
  localparam logic [4:0] M_DOT     = 5'd11;
  localparam logic [4:0] M_BANG    = 5'd12;
  localparam logic [4:0] M_DIRA    = 5'd13;
  localparam logic [4:0] M_DIRD    = 5'd14;
  localparam logic [4:0] M_PLUSL   = 5'd15;
  localparam logic [4:0] M_PLUSE   = 5'd16;
  localparam logic [4:0] M_MACRO   = 5'd17;
  localparam logic [4:0] M_MINUS   = 5'd18;
  localparam logic [4:0] M_LT      = 5'd19;
  localparam logic [4:0] M_GT      = 5'd20;

  localparam logic [3:0] E_NONE      = 4'd0;
  localparam logic [3:0] E_HEX_BIG   = 4'd1;
  localparam logic [3:0] E_NO_HEX    = 4'd2;
  localparam logic [3:0] E_BIN_BIG   = 4'd3;
  localparam logic [3:0] E_DEC_BIG   = 4'd4;
  localparam logic [3:0] E_CHAR_OPEN = 4'd5;
  localparam logic [3:0] E_ESC_OPEN  = 4'd6;
  localparam logic [3:0] E_BAD_ESC   = 4'd7;
  localparam logic [3:0] E_STR_OPEN  = 4'd8;
  localparam logic [3:0] E_BAD_CHAR  = 4'd9;
  localparam logic [3:0] E_LONE_DOT  = 4'd10;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LO_N   = 8'h6e;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_TILDE  = 8'h7e;

  localparam logic [31:0] INT_TOP = 32'h7fff_ffff;
  localparam logic [15:0] RUN_TOP = 16'hffff;

  typedef struct packed {
    logic       load;
    logic [1:0] cnt;
  } step_t;

  function automatic logic is_dg(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_al(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == CH_UNDER;
  endfunction

  function automatic logic is_hx(input logic [7:0] c);
    return is_dg(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  // {ok, decoded byte}
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_LO_N, CH_LO_R:            r = {1'b1, 8'h0d};
      CH_LO_T:                     r = {1'b1, 8'h09};
      CH_BSLASH, CH_QUOTE, CH_DQUOTE: r = {1'b1, c};
      CH_ZERO:                     r = {1'b1, 8'h00};
      default:                     r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ast_lexer.sv -----
// Input register, lexer state and single-pass next-state and result logic.
module ast_lexer #(
  parameter int POS_WIDTH      = 16,
  parameter int HEX_MAX_DIGITS = 8,
  parameter int BIN_MAX_DIGITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  input  logic                        in_tlast,
  input  logic                        free,
  output ast_pkg::step_t              step,
  output logic [5:0]                  r_kind  [3],
  output logic signed [31:0]          r_value [3],
  output logic [POS_WIDTH-1:0]        r_line  [3],
  output logic [POS_WIDTH-1:0]        r_col   [3],
  output logic [POS_WIDTH-1:0]        r_len   [3],
  output logic [3:0]                  r_err   [3]
);
  import ast_pkg::*;

  localparam int DIG_HB  = (HEX_MAX_DIGITS > BIN_MAX_DIGITS) ? HEX_MAX_DIGITS : BIN_MAX_DIGITS;
  localparam int DIG_TOP = (DIG_HB > 63) ? DIG_HB : 63;
  localparam int DW      = $clog2(DIG_TOP + 2);
  localparam logic [POS_WIDTH-1:0] P_ONE = POS_WIDTH'(1);

  typedef struct packed {
    logic [5:0]           kind;
    logic [31:0]          value;
    logic [POS_WIDTH-1:0] col;
    logic [POS_WIDTH-1:0] len;
    logic [3:0]           err;
  } res_t;

  function automatic logic [POS_WIDTH-1:0] satp(input logic [POS_WIDTH-1:0] x);
    return (x == {POS_WIDTH{1'b1}}) ? x : x + P_ONE;
  endfunction

  function automatic res_t mk(input logic [5:0] k, input logic [31:0] v,
                              input logic [POS_WIDTH-1:0] c, input logic [POS_WIDTH-1:0] l,
                              input logic [3:0] e);
    res_t r;
    r.kind = k; r.value = v; r.col = c; r.len = l; r.err = e;
    return r;
  endfunction

  logic                 iv;
  logic [7:0]           c;
  logic                 eos;
  logic                 fire;

  logic [4:0]           mode, mode_next;
  logic [31:0]          acc, acc_next;
  logic [DW-1:0]        dcnt, dcnt_next;
  logic [15:0]          runc, runc_next;
  logic [POS_WIDTH-1:0] line, line_next;
  logic [POS_WIDTH-1:0] colc, colc_next;
  logic [POS_WIDTH-1:0] tstart, tstart_next;
  logic [POS_WIDTH-1:0] tlen, tlen_next;
  logic                 blank, blank_next;
  logic                 esc, esc_next;

  res_t                 r [3];
  logic [1:0]           n;
  logic                 took;
  logic                 eol;

  logic                 c_dg, c_al, c_hx, c_bit;
  logic [3:0]           hv;
  logic [8:0]           ev;
  logic [35:0]          nv;
  logic [DW-1:0]        dinc;
  logic [POS_WIDTH-1:0] cons_len;
  logic [POS_WIDTH-1:0] col_sat;

  assign fire      = iv && free;
  assign in_tready = !iv || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_tready) begin
      iv <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      c   <= in_tdata;
      eos <= in_tlast;
    end
  end

  assign c_dg  = !eos && is_dg(c);
  assign c_al  = !eos && is_al(c);
  assign c_hx  = !eos && is_hx(c);
  assign c_bit = !eos && (c == CH_ZERO || c == CH_ONE);
  assign hv    = is_dg(c) ? c[3:0] : c[3:0] + 4'd9;
  assign ev    = esc_decode(c);
  assign nv    = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, c[3:0]};
  assign dinc  = dcnt + DW'(1);
  assign cons_len = satp(tlen);
  assign col_sat  = satp(colc);

  always_comb begin
    mode_next = mode; acc_next = acc; dcnt_next = dcnt; runc_next = runc;
    line_next = line; colc_next = colc; tstart_next = tstart; tlen_next = tlen;
    blank_next = blank; esc_next = esc;
    for (int i = 0; i < 3; i++) r[i] = '0;
    n = 2'd0; took = 1'b0; eol = 1'b0;

    case (mode)
      M_COMMENT: begin
        if (eos || c == CH_NL) begin
          mode_next = M_START; esc_next = 1'b0;
        end else begin
          took = 1'b1;
        end
      end
      M_HEX: begin
        if (c_hx) begin
          took = 1'b1; tlen_next = cons_len;
          acc_next = {acc[27:0], hv}; dcnt_next = dinc;
          if (dinc > DW'(HEX_MAX_DIGITS)) begin
            r[n] = mk(K_ERROR, 32'd0, col_sat, tlen_next, E_HEX_BIG); n = n + 2'd1;
            mode_next = M_START; esc_next = 1'b0;
          end
        end else begin
          if (dcnt == '0) r[n] = mk(K_ERROR, 32'd0, colc, tlen, E_NO_HEX);
          else r[n] = mk(K_NUMBER, acc, tstart, tlen, E_NONE);
          n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end
      end
      M_PCT, M_BIN: begin
        if (c_bit) begin
          took = 1'b1; tlen_next = cons_len; mode_next = M_BIN;
          acc_next = {acc[30:0], c[0]}; dcnt_next = dinc;
          if (dinc > DW'(BIN_MAX_DIGITS)) begin
            r[n] = mk(K_ERROR, 32'd0, col_sat, tlen_next, E_BIN_BIG); n = n + 2'd1;
            mode_next = M_START; esc_next = 1'b0;
          end
        end else begin
          r[n] = mk((mode == M_PCT) ? K_PERCENT : K_NUMBER,
                    (mode == M_PCT) ? 32'd0 : acc, tstart, tlen, E_NONE);
          n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end
      end
      M_DEC, M_DIRD: begin
        if (c_dg) begin
          took = 1'b1; tlen_next = cons_len;
          if (nv[35:31] != 5'd0) begin
            if (mode == M_DIRD) begin
              r[n] = mk(K_BANG, 32'd0, tstart, P_ONE, E_NONE); n = n + 2'd1;
              r[n] = mk(K_ERROR, 32'd0, col_sat, tlen_next - P_ONE, E_DEC_BIG);
              n = n + 2'd1;
            end else begin
              r[n] = mk(K_ERROR, 32'd0, col_sat, tlen_next, E_DEC_BIG); n = n + 2'd1;
            end
            mode_next = M_START; esc_next = 1'b0;
          end else begin
            acc_next = nv[31:0];
            if (dcnt < DW'(63)) dcnt_next = dinc;
          end
        end else begin
          if (mode == M_DEC) begin
            r[n] = mk(K_NUMBER, acc, tstart, tlen, E_NONE); n = n + 2'd1;
          end else if (dcnt == DW'(2) && (acc == 32'd8 || acc == 32'd16 ||
                       acc == 32'd24 || acc == 32'd32)) begin
            r[n] = mk(K_DIR, 32'd0, tstart, tlen, E_NONE); n = n + 2'd1;
          end else begin
            r[n] = mk(K_BANG, 32'd0, tstart, P_ONE, E_NONE); n = n + 2'd1;
            r[n] = mk(K_NUMBER, acc, satp(tstart), tlen - P_ONE, E_NONE); n = n + 2'd1;
          end
          mode_next = M_START; esc_next = 1'b0;
        end
      end
      M_CH: begin
        if (eos) begin
          r[n] = mk(K_ERROR, 32'd0, colc, tlen, esc ? E_ESC_OPEN : E_CHAR_OPEN);
          n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end else begin
          took = 1'b1; tlen_next = cons_len;
          if (!esc) begin
            if (c == CH_BSLASH) begin
              esc_next = 1'b1;
            end else begin
              acc_next = {24'd0, c}; mode_next = M_CHEND;
            end
          end else begin
            esc_next = 1'b0;
            if (!ev[8]) begin
              r[n] = mk(K_ERROR, 32'd0, col_sat, tlen_next, E_BAD_ESC); n = n + 2'd1;
              mode_next = M_START;
            end else begin
              acc_next = {24'd0, ev[7:0]}; mode_next = M_CHEND;
            end
          end
        end
      end
      M_CHEND: begin
        if (!eos && c == CH_QUOTE) begin
          took = 1'b1; tlen_next = cons_len;
          r[n] = mk(K_CHAR, acc, tstart, tlen_next, E_NONE); n = n + 2'd1;
        end else begin
          r[n] = mk(K_ERROR, 32'd0, colc, tlen, E_CHAR_OPEN); n = n + 2'd1;
        end
        mode_next = M_START; esc_next = 1'b0;
      end
      M_STR: begin
        if (eos || (!esc && c == CH_NL)) begin
          r[n] = mk(K_ERROR, 32'd0, colc, tlen, E_STR_OPEN); n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end else begin
          took = 1'b1; tlen_next = cons_len;
          if (esc) begin
            esc_next = 1'b0;
            if (!ev[8]) begin
              r[n] = mk(K_ERROR, 32'd0, col_sat, tlen_next, E_BAD_ESC); n = n + 2'd1;
              mode_next = M_START;
            end else begin
              r[n] = mk(K_BYTE, {24'd0, ev[7:0]}, colc, POS_WIDTH'(2), E_NONE);
              n = n + 2'd1;
              if (acc < INT_TOP) acc_next = acc + 32'd1;
            end
          end else if (c == CH_DQUOTE) begin
            r[n] = mk(K_STRING, acc, tstart, tlen_next, E_NONE); n = n + 2'd1;
            mode_next = M_START;
          end else if (c == CH_BSLASH) begin
            esc_next = 1'b1;
          end else begin
            r[n] = mk(K_BYTE, {24'd0, c}, colc, P_ONE, E_NONE); n = n + 2'd1;
            if (acc < INT_TOP) acc_next = acc + 32'd1;
          end
        end
      end
      M_IDENT, M_LOCAL, M_MACRO, M_DIRA: begin
        if (c_al || c_dg) begin
          took = 1'b1; tlen_next = cons_len;
        end else begin
          r[n] = mk((mode == M_IDENT) ? K_IDENT : (mode == M_LOCAL) ? K_LOCAL :
                    (mode == M_MACRO) ? K_MACRO : K_DIR, 32'd0, tstart, tlen, E_NONE);
          n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end
      end
      M_DOT: begin
        if (c_al) begin
          took = 1'b1; tlen_next = cons_len; mode_next = M_LOCAL;
        end else begin
          r[n] = mk(K_ERROR, 32'd0, tstart, P_ONE, E_LONE_DOT); n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end
      end
      M_BANG: begin
        if (c_al) begin
          took = 1'b1; tlen_next = cons_len; mode_next = M_DIRA;
        end else if (c_dg) begin
          took = 1'b1; tlen_next = cons_len; mode_next = M_DIRD;
          acc_next = {28'd0, c[3:0]}; dcnt_next = DW'(1);
        end else begin
          r[n] = mk(K_BANG, 32'd0, tstart, tlen, E_NONE); n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end
      end
      M_PLUSL, M_PLUSE: begin
        if (!eos && c == CH_PLUS) begin
          took = 1'b1; tlen_next = cons_len;
          if (runc != RUN_TOP) runc_next = runc + 16'd1;
        end else if (runc == 16'd1 && c_al && mode == M_PLUSL) begin
          took = 1'b1; tlen_next = cons_len; mode_next = M_MACRO;
        end else begin
          if (runc == 16'd1 && (c_al || c_dg || (!eos && (c inside {CH_DOLLAR, CH_PCT,
              CH_LPAREN, CH_QUOTE, CH_STAR, CH_LT, CH_GT, CH_MINUS, CH_TILDE, CH_BANG}))))
            r[n] = mk(K_PLUS, 32'd0, tstart, tlen, E_NONE);
          else
            r[n] = mk(K_AFWD, {16'd0, runc}, tstart, tlen, E_NONE);
          n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end
      end
      M_MINUS: begin
        if (!eos && c == CH_MINUS) begin
          took = 1'b1; tlen_next = cons_len;
          if (runc != RUN_TOP) runc_next = runc + 16'd1;
        end else begin
          if (runc == 16'd1 && (c_al || c_dg ||
              (!eos && (c inside {CH_DOLLAR, CH_PCT, CH_LPAREN}))))
            r[n] = mk(K_MINUS, 32'd0, tstart, tlen, E_NONE);
          else
            r[n] = mk(K_ABACK, {16'd0, runc}, tstart, tlen, E_NONE);
          n = n + 2'd1;
          mode_next = M_START; esc_next = 1'b0;
        end
      end
      M_LT: begin
        if (!eos && (c inside {CH_LT, CH_EQ, CH_GT})) begin
          took = 1'b1; tlen_next = cons_len;
          r[n] = mk((c == CH_LT) ? K_LSHIFT : (c == CH_EQ) ? K_LE : K_NE,
                    32'd0, tstart, tlen_next, E_NONE);
        end else begin
          r[n] = mk(K_LT, 32'd0, tstart, tlen, E_NONE);
        end
        n = n + 2'd1;
        mode_next = M_START; esc_next = 1'b0;
      end
      M_GT: begin
        if (!eos && (c inside {CH_GT, CH_EQ})) begin
          took = 1'b1; tlen_next = cons_len;
          r[n] = mk((c == CH_GT) ? K_RSHIFT : K_GE, 32'd0, tstart, tlen_next, E_NONE);
        end else begin
          r[n] = mk(K_GT, 32'd0, tstart, tlen, E_NONE);
        end
        n = n + 2'd1;
        mode_next = M_START; esc_next = 1'b0;
      end
      default: begin
        mode_next = M_START;
      end
    endcase

    if (eos) begin
      r[n] = mk(K_EOF, 32'd0, colc, '0, E_NONE); n = n + 2'd1;
      mode_next = M_START; acc_next = '0; dcnt_next = '0; runc_next = '0;
      line_next = P_ONE; colc_next = P_ONE; tstart_next = P_ONE; tlen_next = '0;
      blank_next = 1'b1; esc_next = 1'b0;
    end else begin
      if (!took) begin
        tstart_next = colc; tlen_next = P_ONE;
        acc_next = '0; dcnt_next = '0; esc_next = 1'b0; runc_next = 16'd1;
        case (c)
          CH_SP, CH_TAB, CH_CR: ;
          CH_SEMI:   mode_next = M_COMMENT;
          CH_NL: begin
            r[n] = mk(K_EOL, 32'd0, colc, P_ONE, E_NONE); n = n + 2'd1; eol = 1'b1;
          end
          CH_DOLLAR: mode_next = M_HEX;
          CH_PCT:    mode_next = M_PCT;
          CH_QUOTE:  mode_next = M_CH;
          CH_DQUOTE: mode_next = M_STR;
          CH_DOT:    mode_next = M_DOT;
          CH_BANG:   mode_next = M_BANG;
          CH_PLUS:   mode_next = blank ? M_PLUSL : M_PLUSE;
          CH_MINUS:  mode_next = M_MINUS;
          CH_LT:     mode_next = M_LT;
          CH_GT:     mode_next = M_GT;
          CH_STAR, CH_SLASH, CH_AMP, CH_PIPE, CH_CARET, CH_TILDE, CH_EQ, CH_LPAREN,
          CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON,
          CH_HASH: begin
            r[n] = mk((c == CH_STAR)   ? K_STAR   : (c == CH_SLASH)  ? K_SLASH :
                      (c == CH_AMP)    ? K_AMP    : (c == CH_PIPE)   ? K_PIPE :
                      (c == CH_CARET)  ? K_CARET  : (c == CH_TILDE)  ? K_TILDE :
                      (c == CH_EQ)     ? K_EQ     : (c == CH_LPAREN) ? K_LPAREN :
                      (c == CH_RPAREN) ? K_RPAREN : (c == CH_LBRACE) ? K_LBRACE :
                      (c == CH_RBRACE) ? K_RBRACE : (c == CH_LBRACK) ? K_LBRACKET :
                      (c == CH_RBRACK) ? K_RBRACKET : (c == CH_COMMA) ? K_COMMA :
                      (c == CH_COLON)  ? K_COLON  : K_HASH,
                      32'd0, colc, P_ONE, E_NONE);
            n = n + 2'd1;
          end
          default: begin
            if (is_dg(c)) begin
              mode_next = M_DEC; acc_next = {28'd0, c[3:0]}; dcnt_next = DW'(1);
            end else if (is_al(c)) begin
              mode_next = M_IDENT;
            end else begin
              r[n] = mk(K_ERROR, 32'd0, col_sat, P_ONE, E_BAD_CHAR); n = n + 2'd1;
            end
          end
        endcase
      end
      if (eol) begin
        line_next = satp(line); colc_next = P_ONE; blank_next = 1'b1;
      end else begin
        colc_next = col_sat;
        if (c == CH_COLON) blank_next = 1'b1;
        else if (c != CH_SP && c != CH_TAB) blank_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_START; acc <= '0; dcnt <= '0; runc <= '0;
      line <= P_ONE; colc <= P_ONE; tstart <= P_ONE; tlen <= '0;
      blank <= 1'b1; esc <= 1'b0;
    end else if (fire) begin
      mode <= mode_next; acc <= acc_next; dcnt <= dcnt_next; runc <= runc_next;
      line <= line_next; colc <= colc_next; tstart <= tstart_next; tlen <= tlen_next;
      blank <= blank_next; esc <= esc_next;
    end
  end

  assign step.load = fire;
  assign step.cnt  = n;

  for (genvar g = 0; g < 3; g++) begin : g_res
    assign r_kind[g]  = r[g].kind;
    assign r_value[g] = r[g].value;
    assign r_line[g]  = line;
    assign r_col[g]   = r[g].col;
    assign r_len[g]   = r[g].len;
    assign r_err[g]   = r[g].err;
  end

endmodule

// ----- sv/ast_emit.sv -----
// Result register holding one beat's group of up to three tokens and draining it.
module ast_emit #(
  parameter int POS_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ast_pkg::step_t       step,
  input  logic [5:0]           r_kind  [3],
  input  logic signed [31:0]   r_value [3],
  input  logic [POS_WIDTH-1:0] r_line  [3],
  input  logic [POS_WIDTH-1:0] r_col   [3],
  input  logic [POS_WIDTH-1:0] r_len   [3],
  input  logic [3:0]           r_err   [3],
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [5:0]           o_kind,
  output logic signed [31:0]   o_value,
  output logic [POS_WIDTH-1:0] o_line,
  output logic [POS_WIDTH-1:0] o_col,
  output logic [POS_WIDTH-1:0] o_len,
  output logic [3:0]           o_err,
  output logic                 out_tlast
);
  import ast_pkg::*;

  logic                 valid;
  logic [1:0]           idx;
  logic [1:0]           cnt;
  logic [5:0]           kind  [3];
  logic signed [31:0]   value [3];
  logic [POS_WIDTH-1:0] line  [3];
  logic [POS_WIDTH-1:0] col   [3];
  logic [POS_WIDTH-1:0] len   [3];
  logic [3:0]           err   [3];
  logic                 at_end;
  logic                 ld;

  assign at_end = idx == cnt - 2'd1;
  assign free   = !valid || (out_tready && at_end);
  assign ld     = step.load && step.cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
      cnt   <= 2'd0;
    end else if (ld) begin
      valid <= 1'b1;
      idx   <= 2'd0;
      cnt   <= step.cnt;
    end else if (valid && out_tready) begin
      if (at_end) valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
    if (ld) begin
      kind <= r_kind; value <= r_value; line <= r_line;
      col  <= r_col;  len   <= r_len;   err  <= r_err;
    end
  end

  assign out_tvalid = valid;
  assign out_tlast  = at_end;
  assign o_kind     = kind[idx];
  assign o_value    = value[idx];
  assign o_line     = line[idx];
  assign o_col      = col[idx];
  assign o_len      = len[idx];
  assign o_err      = err[idx];

  a_cnt_ok: assert property (@(posedge clk) disable iff (rst)
    valid |-> (cnt != 2'd0 && idx < cnt))
    else $error("result group index out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_tready) |=> (valid && $stable(idx)))
    else $error("stalled result group moved");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (step.load && step.cnt != 2'd0) |-> ($past(1'b1) && (!valid || (out_tready && at_end))))
    else $error("result group overwritten before drained");

endmodule

// ----- sv/assembler_source_tokenizer.sv -----
// Top level of the streaming assembler source tokenizer.
// One source byte is taken per beat, one beat per cycle when the output keeps up;
// each byte is lexed combinationally from the input register into a result
// register that holds any tokens it causes, up to three. Output beats go one per
// cycle while m_axis_tready is high, so a byte causing several results holds the
// input until the single result port has sent its last result. A byte
// with tlast set closes the pending token, emits EOF and returns all state to reset.
module assembler_source_tokenizer #(
  parameter int POS_WIDTH      = 16,
  parameter int HEX_MAX_DIGITS = 8,
  parameter int BIN_MAX_DIGITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // source_byte
  input  logic s_axis_tlast,         // end_of_source
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // token_kind, token_value, line_number, column, token_length, error_code
  output logic [((42 + 3 * POS_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tlast           // last_of_run
);
  import ast_pkg::*;

  localparam int OUT_W = ((42 + 3 * POS_WIDTH + 7) / 8) * 8;

  step_t                step;
  logic                 free;
  logic [5:0]           r_kind  [3];
  logic signed [31:0]   r_value [3];
  logic [POS_WIDTH-1:0] r_line  [3];
  logic [POS_WIDTH-1:0] r_col   [3];
  logic [POS_WIDTH-1:0] r_len   [3];
  logic [3:0]           r_err   [3];
  logic [5:0]           o_kind;
  logic signed [31:0]   o_value;
  logic [POS_WIDTH-1:0] o_line;
  logic [POS_WIDTH-1:0] o_col;
  logic [POS_WIDTH-1:0] o_len;
  logic [3:0]           o_err;

  ast_lexer #(
    .POS_WIDTH(POS_WIDTH), .HEX_MAX_DIGITS(HEX_MAX_DIGITS), .BIN_MAX_DIGITS(BIN_MAX_DIGITS)
  ) u_lexer (
    .clk(clk), .rst(rst),
    .in_tvalid(s_axis_tvalid), .in_tready(s_axis_tready),
    .in_tdata(s_axis_tdata), .in_tlast(s_axis_tlast),
    .free(free), .step(step),
    .r_kind(r_kind), .r_value(r_value), .r_line(r_line),
    .r_col(r_col), .r_len(r_len), .r_err(r_err)
  );

  ast_emit #(.POS_WIDTH(POS_WIDTH)) u_emit (
    .clk(clk), .rst(rst), .step(step),
    .r_kind(r_kind), .r_value(r_value), .r_line(r_line),
    .r_col(r_col), .r_len(r_len), .r_err(r_err),
    .free(free), .out_tvalid(m_axis_tvalid), .out_tready(m_axis_tready),
    .o_kind(o_kind), .o_value(o_value), .o_line(o_line),
    .o_col(o_col), .o_len(o_len), .o_err(o_err), .out_tlast(m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({o_err, o_len, o_col, o_line, o_value, o_kind});

endmodule
